// ===== hw/rtl/wind_report_frame_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// Wind report frame encoder assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef WIND_REPORT_FRAME_ENCODER_MACROS_SVH
`define WIND_REPORT_FRAME_ENCODER_MACROS_SVH
`ifndef SYNTH
`define WRFE_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("wrfe assertion failed");
`define WRFE_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("wrfe assertion failed");
`else
`define WRFE_ASSERT_IMP(lbl, a, b)
`define WRFE_ASSERT_NXT(lbl, a, b)
`endif
`endif

// ===== hw/rtl/wrfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Wind report frame encoder package
// Shared types, constants and field encoders.
// ----------------------------------------------------------------------------
package wrfe_pkg;

  localparam int DIAG_ROTATION_DEF = 15;
  localparam int DIAG_ENTRIES = 19;
  localparam int NUM_W = 44;
  localparam int DEN_W = 36;
  localparam int REM_W = NUM_W + 2;

  localparam logic [7:0] DIAG_ERROR = 8'hFF;
  localparam logic [7:0] DIAG_VERSION = 8'h01;
  localparam logic [7:0] SHORT_MARK = 8'h50;
  localparam logic [2:0] LAST_PAIR = 3'd7;
  localparam logic [2:0] LAST_SHORT = 3'd5;

  localparam logic [4:0] E_ACC_X_SUM = 5'd0;
  localparam logic [4:0] E_ACC_Y_SUM = 5'd2;
  localparam logic [4:0] E_ACC_Z_SUM = 5'd4;
  localparam logic [4:0] E_HERR_SUM = 5'd6;
  localparam logic [4:0] E_HERR_MAX = 5'd8;
  localparam logic [4:0] E_TEMP_SUM = 5'd9;
  localparam logic [4:0] E_TEMP_MIN = 5'd11;
  localparam logic [4:0] E_TEMP_MAX = 5'd12;
  localparam logic [4:0] E_VOLT_BASE = 5'd12;

  localparam logic [31:0] MAX_RESET = 32'hFFFF_D8F1;
  localparam logic [31:0] MIN_RESET = 32'h0000_270F;

  localparam logic [3:0] PH_VERSION = 4'd0;
  localparam logic [3:0] PH_VOLT_FIRST = 4'd1;
  localparam logic [3:0] PH_VOLT_LAST = 4'd6;
  localparam logic [3:0] PH_ACC_X = 4'd7;
  localparam logic [3:0] PH_ACC_Y = 4'd8;
  localparam logic [3:0] PH_ACC_Z = 4'd9;
  localparam logic [3:0] PH_HERR_AVG = 4'd10;
  localparam logic [3:0] PH_HERR_MAX = 4'd11;
  localparam logic [3:0] PH_TEMP_AVG = 4'd12;
  localparam logic [3:0] PH_TEMP_MIN = 4'd13;
  localparam logic [3:0] PH_TEMP_MAX = 4'd14;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [1:0] {TS_IDLE, TS_DIAG, TS_WAIT, TS_OUT} wrfe_state_t;
  typedef enum logic [1:0] {DV_IDLE, DV_PREP, DV_ITER, DV_FIN} wrfe_div_state_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic signed [8:0]       off;
  } wrfe_div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] value;
  } wrfe_div_rsp_t;

  function automatic logic [7:0] enc_speed(input logic [11:0] v);
    logic [12:0] t;
    logic [7:0]  r;
    begin
      t = 13'(v);
      if (v < 12'd160) begin
        r = 8'((t + 13'd2) >> 2);
      end else if (v < 12'd1280) begin
        r = 8'((t + 13'd4) >> 3) + 8'd20;
      end else if (v < 12'd1920) begin
        r = 8'((t + 13'd8) >> 4) + 8'd100;
      end else if (v < 12'd3040) begin
        r = 8'((t + 13'd16) >> 5) + 8'd160;
      end else begin
        r = 8'hFF;
      end
      return r;
    end
  endfunction

  function automatic logic [3:0] enc_head_low(input logic [15:0] h);
    logic [16:0] t;
    begin
      t = 17'(h) + 17'd2048;
      return t[15:12];
    end
  endfunction

  function automatic logic [7:0] enc_head_high(input logic [15:0] h);
    logic [23:0] p;
    begin
      p = 24'(h) * 24'd180 + 24'd32768;
      return (p[23:16] == 8'd180) ? 8'd0 : p[23:16];
    end
  endfunction

endpackage

// ===== hw/rtl/wrfe_div.sv =====
// ----------------------------------------------------------------------------
// Wind report frame encoder rounding divider
// Signed divide, rounded half away from zero, offset and clamp to 0..254.
// ----------------------------------------------------------------------------
module wrfe_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wrfe_pkg::wrfe_div_req_t req,
  output wrfe_pkg::wrfe_div_rsp_t rsp
);
  import wrfe_pkg::*;

  wrfe_div_state_t state_r, state_nxt;
  logic [REM_W-1:0] num_r, num_nxt;
  logic [REM_W-1:0] dsh_r, dsh_nxt;
  logic [8:0]       q_r, q_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic             neg_r, neg_nxt;
  logic signed [8:0] off_r, off_nxt;
  logic [NUM_W-1:0] an;
  logic [DEN_W-1:0] ad;
  logic signed [10:0] sval;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    bit_r <= bit_nxt;
    neg_r <= neg_nxt;
    off_r <= off_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    dsh_nxt   = dsh_r;
    q_nxt     = q_r;
    bit_nxt   = bit_r;
    neg_nxt   = neg_r;
    off_nxt   = off_r;
    an = req.num[NUM_W-1] ? (~req.num + 1'b1) : req.num;
    ad = req.den[DEN_W-1] ? (~req.den + 1'b1) : req.den;
    sval = (neg_r ? -$signed(11'(q_r)) : $signed(11'(q_r))) + 11'(off_r);
    rsp.done  = 1'b0;
    rsp.value = (sval < 0) ? 8'd0 : ((sval > 11'sd254) ? 8'd254 : sval[7:0]);
    unique case (state_r)
      DV_IDLE: begin
        if (req.start) begin
          neg_nxt   = req.num[NUM_W-1] ^ req.den[DEN_W-1];
          num_nxt   = (REM_W'(an) << 1) + REM_W'(ad);
          dsh_nxt   = REM_W'(ad) << 9;
          off_nxt   = req.off;
          q_nxt     = '0;
          state_nxt = DV_PREP;
        end
      end
      DV_PREP: begin
        if (num_r >= dsh_r) begin
          q_nxt     = 9'd256;
          state_nxt = DV_FIN;
        end else begin
          dsh_nxt   = dsh_r >> 1;
          bit_nxt   = 3'd7;
          state_nxt = DV_ITER;
        end
      end
      DV_ITER: begin
        if (num_r >= dsh_r) begin
          num_nxt = num_r - dsh_r;
          q_nxt[bit_r] = 1'b1;
        end
        dsh_nxt = dsh_r >> 1;
        bit_nxt = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          state_nxt = DV_FIN;
        end
      end
      DV_FIN: begin
        rsp.done  = 1'b1;
        state_nxt = DV_IDLE;
      end
      default: state_nxt = DV_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/wind_report_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// Wind report frame encoder
// Encodes wind records and one rotating diagnostic byte into report frames.
// ----------------------------------------------------------------------------
// Input channel (in_*): a write beat (in_command high) sets one diagnostic
// entry without raising in_stall; indexes above 18 are ignored. A report beat
// starts a frame of 8 bytes (in_two_reports high) or 6 bytes.
// in_stall is high from the report beat until its last byte is taken.
// Output channel (out_*): one beat per frame byte, out_last_byte on the last.
// The first byte leaves once the diagnostic byte is set: version, error and
// zero-count diagnostic bytes are set directly, others by the shared divider
// (request, range check, 8 quotient steps, finish; the range check skips the
// quotient steps when it saturates). Bytes then leave one per cycle while
// out_stall is low.
// While out_stall is high the current byte holds and nothing else moves.
// Reset clears the diagnostic store to its start values and the phase to 0.
// ----------------------------------------------------------------------------
module wind_report_frame_encoder #(
  parameter int DIAG_ROTATION = wrfe_pkg::DIAG_ROTATION_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic        in_two_reports,
  input  logic [11:0] in_speed_min_a,
  input  logic [11:0] in_speed_avg_a,
  input  logic [11:0] in_speed_max_a,
  input  logic [15:0] in_heading_a,
  input  logic [11:0] in_speed_min_b,
  input  logic [11:0] in_speed_avg_b,
  input  logic [11:0] in_speed_max_b,
  input  logic [15:0] in_heading_b,
  input  logic [4:0]  in_diag_index,
  input  logic signed [31:0] in_diag_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_byte
);
  import wrfe_pkg::*;

  wrfe_state_t state_r, state_nxt;
  logic [31:0] store_r [DIAG_ENTRIES];
  logic [31:0] store_nxt [DIAG_ENTRIES];
  logic [7:0]  fb_r [8];
  logic [7:0]  fb_nxt [8];
  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [2:0]  lst_r, lst_nxt;
  wrfe_div_req_t div_req;
  wrfe_div_rsp_t div_rsp;
  logic [4:0]  s_idx;
  logic signed [NUM_W-1:0] c_num;
  logic signed [NUM_W-1:0] s_num;

  wrfe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TS_IDLE;
      phase_r <= '0;
      idx_r   <= '0;
      lst_r   <= LAST_SHORT;
      for (int i = 0; i < DIAG_ENTRIES; i++) begin
        store_r[i] <= '0;
      end
      store_r[E_HERR_MAX] <= MAX_RESET;
      store_r[E_TEMP_MIN] <= MIN_RESET;
      store_r[E_TEMP_MAX] <= MAX_RESET;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      lst_r   <= lst_nxt;
      store_r <= store_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fb_r <= fb_nxt;
  end

  assign out_valid      = (state_r == TS_OUT);
  assign out_frame_byte = fb_r[idx_r];
  assign out_last_byte  = (idx_r == lst_r);
  assign in_stall       = (state_r != TS_IDLE);

  always_comb begin
    state_nxt = state_r;
    store_nxt = store_r;
    fb_nxt    = fb_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    lst_nxt   = lst_r;
    div_req   = '0;
    s_idx     = '0;
    c_num     = '0;
    s_num     = '0;
    unique case (state_r)
      TS_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_WRITE) begin
            if (in_diag_index < 5'(DIAG_ENTRIES)) begin
              store_nxt[in_diag_index] = in_diag_value;
            end
          end else if (in_two_reports) begin
            fb_nxt[0] = enc_speed(in_speed_min_a);
            fb_nxt[1] = enc_speed(in_speed_min_b);
            fb_nxt[2] = enc_speed(in_speed_avg_a);
            fb_nxt[3] = enc_speed(in_speed_avg_b);
            fb_nxt[4] = enc_speed(in_speed_max_a);
            fb_nxt[5] = enc_speed(in_speed_max_b);
            fb_nxt[6] = {enc_head_low(in_heading_a), enc_head_low(in_heading_b)};
            lst_nxt   = LAST_PAIR;
            idx_nxt   = '0;
            state_nxt = TS_DIAG;
          end else begin
            fb_nxt[0] = SHORT_MARK;
            fb_nxt[1] = enc_speed(in_speed_min_a);
            fb_nxt[2] = enc_speed(in_speed_avg_a);
            fb_nxt[3] = enc_speed(in_speed_max_a);
            fb_nxt[4] = enc_head_high(in_heading_a);
            lst_nxt   = LAST_SHORT;
            idx_nxt   = '0;
            state_nxt = TS_DIAG;
          end
        end
      end
      TS_DIAG: begin
        phase_nxt = ((5'(phase_r) + 5'd1) >= 5'(DIAG_ROTATION)) ? 4'd0 : (phase_r + 4'd1);
        state_nxt = TS_WAIT;
        div_req.start = 1'b1;
        case (phase_r) inside
          PH_VERSION: begin
            div_req.start = 1'b0;
            fb_nxt[lst_r] = DIAG_VERSION;
            state_nxt     = TS_OUT;
          end
          [PH_VOLT_FIRST:PH_VOLT_LAST]: begin
            s_idx       = 5'(phase_r) + E_VOLT_BASE;
            div_req.num = NUM_W'($signed(store_r[s_idx])) - NUM_W'(1750);
            div_req.den = DEN_W'(10);
          end
          PH_ACC_X, PH_ACC_Y, PH_ACC_Z, PH_HERR_AVG, PH_TEMP_AVG: begin
            case (phase_r)
              PH_ACC_X: s_idx = E_ACC_X_SUM;
              PH_ACC_Y: s_idx = E_ACC_Y_SUM;
              PH_ACC_Z: s_idx = E_ACC_Z_SUM;
              PH_HERR_AVG: s_idx = E_HERR_SUM;
              default: s_idx = E_TEMP_SUM;
            endcase
            c_num = NUM_W'($signed(store_r[s_idx + 5'd1]));
            s_num = NUM_W'($signed(store_r[s_idx]));
            store_nxt[s_idx] = '0;
            store_nxt[s_idx + 5'd1] = '0;
            if (phase_r == PH_TEMP_AVG) begin
              div_req.num = s_num + (c_num <<< 9) + (c_num <<< 8) + (c_num <<< 5);
              div_req.den = DEN_W'(c_num) <<< 3;
            end else begin
              div_req.num = s_num;
              div_req.den = DEN_W'(c_num);
            end
            if (phase_r != PH_HERR_AVG && phase_r != PH_TEMP_AVG) begin
              div_req.off = 9'sd128;
            end
            if (store_r[s_idx + 5'd1] == '0) begin
              div_req.start = 1'b0;
              fb_nxt[lst_r] = DIAG_ERROR;
              state_nxt     = TS_OUT;
            end
          end
          PH_HERR_MAX: begin
            div_req.num = NUM_W'($signed(store_r[E_HERR_MAX]));
            div_req.den = DEN_W'(1);
            store_nxt[E_HERR_MAX] = MAX_RESET;
          end
          PH_TEMP_MIN: begin
            div_req.num = NUM_W'($signed(store_r[E_TEMP_MIN])) + NUM_W'(800);
            div_req.den = DEN_W'(8);
            store_nxt[E_TEMP_MIN] = MIN_RESET;
          end
          PH_TEMP_MAX: begin
            div_req.num = NUM_W'($signed(store_r[E_TEMP_MAX])) + NUM_W'(800);
            div_req.den = DEN_W'(8);
            store_nxt[E_TEMP_MAX] = MAX_RESET;
          end
          default: begin
            div_req.start = 1'b0;
            fb_nxt[lst_r] = DIAG_ERROR;
            state_nxt     = TS_OUT;
          end
        endcase
      end
      TS_WAIT: begin
        if (div_rsp.done) begin
          fb_nxt[lst_r] = div_rsp.value;
          state_nxt     = TS_OUT;
        end
      end
      TS_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == lst_r) begin
            idx_nxt   = '0;
            state_nxt = TS_IDLE;
          end
        end
      end
      default: state_nxt = TS_IDLE;
    endcase
  end

`include "wind_report_frame_encoder_macros.svh"

  `WRFE_ASSERT_IMP(a_out_blocks_in, out_valid, in_stall)
  `WRFE_ASSERT_NXT(a_last_ends_frame, out_valid && !out_stall && out_last_byte, !out_valid)
  `WRFE_ASSERT_NXT(a_report_stalls, in_valid && !in_stall && (in_command == CMD_REPORT), in_stall)
  `WRFE_ASSERT_IMP(a_phase_range, 1'b1, 5'(phase_r) < 5'(DIAG_ROTATION))

endmodule
